// ----- sv/guarded_page_frame_allocator_macros.svh -----
// Assertion macros for the guarded page frame allocator.
// Used by the top level only; needs no other file.
`ifndef GUARDED_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define GUARDED_PAGE_FRAME_ALLOCATOR_MACROS_SVH
// implication checked on every rising edge outside reset
`define GPFA_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define GPFA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- sv/gpfa_pkg.sv -----
// Shared types and codes for the guarded page frame allocator.
// No dependencies.
package gpfa_pkg;
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;

    localparam int FRAME_W = 20;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_ASCAN,
        S_AWAIT,
        S_FCHK,
        S_FSCAN,
        S_FCHK2,
        S_FSHIFT,
        S_FWAIT,
        S_RREAD,
        S_DONE
    } t_state;
endpackage

// ----- sv/guarded_page_frame_allocator.sv -----
// Guarded page frame allocator: one request at a time, state in two memories.
// Throughput: one request in flight; busy high from accept until o_valid.
// Reset: synchronous active low; a clearing pass then marks every page free
// with busy held high. Results cannot be stalled.
// Depends on gpfa_pkg and guarded_page_frame_allocator_macros.svh.
`include "guarded_page_frame_allocator_macros.svh"
module guarded_page_frame_allocator import gpfa_pkg::*; #(
    parameter int NUM_PAGES   = 4096,
    parameter int MAX_RECORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_page_address,
    input  logic [11:0] i_record_position,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_address
);
    localparam int PW = $clog2(NUM_PAGES);
    localparam int RW = $clog2(MAX_RECORDS);
    localparam int PC = PW + 1;   // page count width
    localparam int RC = RW + 1;   // record count width

    // ---------------- configuration registers
    logic [19:0] r_first;
    logic [12:0] r_pages;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_pages <= 13'd4096;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == 1'b0) r_first <= pwdata[19:0];
            else                  r_pages <= pwdata[12:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {19'd0, r_pages} : {12'd0, r_first};

    // effective region size, at most NUM_PAGES
    logic [PC-1:0] eff;
    always_comb begin
        if (32'(r_pages) < 32'(NUM_PAGES)) eff = PC'(r_pages);
        else                               eff = PC'(NUM_PAGES);
    end

    // ---------------- memories: free map (1 = allocated) and records
    logic          used_mem [NUM_PAGES];
    logic [19:0]   rec_mem  [MAX_RECORDS];
    logic          u_we, u_wd;
    logic [PW-1:0] u_wa, u_ra;
    logic          r_u_rd;
    logic          c_we;
    logic [RW-1:0] c_wa, c_ra;
    logic [19:0]   c_wd, r_c_rd;
    always_ff @(posedge i_clk) begin
        if (u_we) used_mem[u_wa] <= u_wd;
        r_u_rd <= used_mem[u_ra];
    end
    always_ff @(posedge i_clk) begin
        if (c_we) rec_mem[c_wa] <= c_wd;
        r_c_rd <= rec_mem[c_ra];
    end

    // ---------------- control
    t_state        r_state, n_state;
    logic [PC-1:0] r_idx, n_idx;      // scan index / clear index
    logic [RC-1:0] r_k, n_k;          // record walk index
    logic [RC-1:0] r_cnt, n_cnt;
    logic [31:0]   r_addr;
    logic [11:0]   r_pos;
    // sliding window of used bits: r_w1 = page idx+2, r_w0 = page idx+1
    logic          r_w1, r_w0, n_w1, n_w0;
    logic [1:0]    r_st, n_st;
    logic [31:0]   r_res, n_res;
    logic          r_ov, n_ov;
    logic          r_fresh, n_fresh;  // data read this cycle is valid

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_status = r_st;
    assign o_result_address = r_res;

    logic [19:0] f_frame, f_idx;
    assign f_frame = r_addr[31:12];
    assign f_idx   = f_frame - r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_k     <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_fresh <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
            r_fresh <= n_fresh;
        end
    end
    always_ff @(posedge i_clk) begin
        r_w1  <= n_w1;
        r_w0  <= n_w0;
        r_st  <= n_st;
        r_res <= n_res;
        if (start && !busy) begin
            r_addr <= i_page_address;
            r_pos  <= i_record_position;
        end
    end

    logic [19:0] g_frame;
    logic [PC-1:0] cur;     // page judged this cycle = r_idx + 1 (window centre)

    always_comb begin
        n_state = r_state;
        n_idx = r_idx; n_k = r_k; n_cnt = r_cnt;
        n_w1 = r_w1; n_w0 = r_w0;
        n_st = r_st; n_res = r_res;
        n_ov = 1'b0; n_fresh = 1'b0;
        u_we = 1'b0; u_wd = 1'b0; u_wa = r_idx[PW-1:0]; u_ra = r_idx[PW-1:0];
        c_we = 1'b0; c_wd = r_c_rd; c_wa = r_k[RW-1:0]; c_ra = r_k[RW-1:0];
        g_frame = '0; cur = '0;
        case (r_state)
            S_CLEAR: begin
                u_we = 1'b1; u_wd = 1'b0;
                n_idx = r_idx + 1'b1;
                if (r_idx == PC'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                    n_idx = '0;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_st = ST_NONE; n_res = '0;
                    n_k = '0;
                    case (i_op)
                        OP_ALLOC: begin
                            if (eff < PC'(2) || r_cnt >= RC'(MAX_RECORDS)) begin
                                n_state = S_DONE;
                            end else begin
                                // prime: above the top counts as free
                                n_w1 = 1'b0; n_w0 = 1'b0;
                                n_idx = eff - 1'b1;
                                u_ra = n_idx[PW-1:0];
                                n_state = S_ASCAN;
                                n_fresh = 1'b1;
                            end
                        end
                        OP_FREE:  n_state = S_FCHK;
                        OP_READ: begin
                            c_ra = RW'(i_record_position);
                            n_state = S_RREAD;
                        end
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_ASCAN: begin
                // r_u_rd holds page r_idx; window holds pages r_idx+2, r_idx+1
                // judge page r_idx+1 once it exists
                n_w1 = r_w0; n_w0 = r_u_rd;
                cur = r_idx + 1'b1;
                if (cur < eff && !r_w0 && !r_w1 && !r_u_rd) begin
                    n_state = S_AWAIT; n_idx = cur;
                end else if (r_idx == '0) begin
                    // judge page 0: below it counts free
                    if (!r_u_rd && !r_w0) begin
                        n_state = S_AWAIT; n_idx = '0;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_idx = r_idx - 1'b1;
                    u_ra = n_idx[PW-1:0];
                end
            end
            S_AWAIT: begin
                g_frame = r_first + 20'(r_idx);
                u_we = 1'b1; u_wd = 1'b1;
                c_we = 1'b1; c_wa = r_cnt[RW-1:0]; c_wd = g_frame;
                n_cnt = r_cnt + 1'b1;
                n_st = ST_OK; n_res = {g_frame, 12'd0};
                n_state = S_DONE;
            end
            S_FCHK: begin
                if (r_addr[11:0] != 12'd0 || 32'(f_idx) >= 32'(eff)) begin
                    n_st = ST_BADADDR; n_state = S_DONE;
                end else begin
                    n_st = ST_OK;
                    n_idx = PC'(f_idx);
                    u_ra = f_idx[PW-1:0];
                    n_fresh = 1'b1;
                    n_state = S_FSCAN;
                    n_k = '0;
                    c_ra = '0;
                end
            end
            S_FSCAN: begin
                // first cycle: r_u_rd is the page's used bit
                if (r_fresh && !r_u_rd) begin
                    n_state = S_DONE;
                end else begin
                    if (r_fresh) begin
                        u_we = 1'b1; u_wd = 1'b0;
                    end
                    // r_c_rd holds record r_k
                    if (r_k >= r_cnt) begin
                        n_state = S_DONE;
                    end else if (r_c_rd == f_frame) begin
                        n_state = S_FSHIFT;
                        c_ra = RW'(r_k + 1'b1);
                    end else begin
                        n_k = r_k + 1'b1;
                        c_ra = n_k[RW-1:0];
                        n_fresh = 1'b0;
                        if (r_fresh) n_state = S_FSCAN;
                        if (!r_fresh) n_state = S_FCHK2;
                    end
                end
            end
            S_FCHK2: begin
                // wait for record r_k
                n_state = S_FSCAN;
                c_ra = r_k[RW-1:0];
            end
            S_FSHIFT: begin
                // r_c_rd holds record r_k+1: move it down
                if (r_k + 1'b1 >= r_cnt) begin
                    n_cnt = r_cnt - 1'b1;
                    n_state = S_DONE;
                end else begin
                    c_we = 1'b1; c_wa = r_k[RW-1:0]; c_wd = r_c_rd;
                    n_k = r_k + 1'b1;
                    c_ra = RW'(r_k + 2'd2);
                    n_state = S_FWAIT;
                end
            end
            S_FWAIT: begin
                c_ra = RW'(r_k + 1'b1);
                n_state = S_FSHIFT;
            end
            S_RREAD: begin
                if (RC'(r_pos) < r_cnt && 32'(r_pos) < 32'(MAX_RECORDS)) begin
                    n_st = ST_OK; n_res = {r_c_rd, 12'd0};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                n_ov = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    `GPFA_ASSERT(a_cnt_range, 1'b1, r_cnt <= RC'(MAX_RECORDS), "record count overflow")
    `GPFA_ASSERT_NXT(a_valid_idle, r_state == S_DONE, o_valid && !busy, "result not issued")
    `GPFA_ASSERT(a_no_start, o_valid, $past(r_state) == S_DONE, "stray result strobe")
endmodule
